// ----- hw/rtl/lpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpd_pkg: shared types and constants of the length-prefixed packet deframer
// Holds the field widths and the result word that passes from the parser to
// the output register.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned HDR_IDX_W = 6;
    // Number of header bytes that carry the length (little-endian).
    localparam int unsigned LEN_BYTES = 4;
    localparam int unsigned OUT_DATA_W = 40;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [HDR_IDX_W-1:0] hdr_idx_t;

    typedef struct packed {
        logic  valid;
        byte_t payload_byte;
        logic  first_of_packet;
        logic  last_of_packet;
        len_t  packet_length;
    } result_t;

endpackage

// ----- hw/rtl/lpd_parser.sv -----
// ----------------------------------------------------------------------------
// lpd_parser: header and payload tracking
// Walks the header, assembles the length and counts the payload bytes down.
// ----------------------------------------------------------------------------
module lpd_parser #(
    parameter int unsigned HEADER_BYTES = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  lpd_pkg::byte_t        data_byte,
    output lpd_pkg::result_t      result
);

    localparam lpd_pkg::hdr_idx_t HDR_LAST = lpd_pkg::HDR_IDX_W'(HEADER_BYTES - 1);
    localparam lpd_pkg::hdr_idx_t LEN_END  = lpd_pkg::HDR_IDX_W'(lpd_pkg::LEN_BYTES);

    logic              in_payload_reg, in_payload_next;
    lpd_pkg::hdr_idx_t header_index_reg, header_index_next;
    lpd_pkg::len_t     length_accum_reg, length_accum_next;
    lpd_pkg::len_t     bytes_remaining_reg, bytes_remaining_next;
    lpd_pkg::len_t     remaining_dec;

    assign remaining_dec = bytes_remaining_reg - lpd_pkg::LEN_W'(1);

    always_comb begin
        in_payload_next      = in_payload_reg;
        header_index_next    = header_index_reg;
        length_accum_next    = length_accum_reg;
        bytes_remaining_next = bytes_remaining_reg;

        result.valid           = accept && in_payload_reg;
        result.payload_byte    = data_byte;
        result.first_of_packet = (bytes_remaining_reg == length_accum_reg);
        result.last_of_packet  = (bytes_remaining_reg == lpd_pkg::LEN_W'(1));
        result.packet_length   = length_accum_reg;

        if (accept) begin
            if (!in_payload_reg) begin
                // Length bytes arrive least significant first.
                if (header_index_reg < LEN_END) begin
                    case (header_index_reg[1:0])
                        2'd0: length_accum_next = {24'd0, data_byte};
                        2'd1: length_accum_next[15:8]  = data_byte;
                        2'd2: length_accum_next[23:16] = data_byte;
                        default: length_accum_next[31:24] = data_byte;
                    endcase
                end
                if (header_index_reg >= HDR_LAST) begin
                    header_index_next = '0;
                    if (length_accum_next != '0) begin
                        in_payload_next      = 1'b1;
                        bytes_remaining_next = length_accum_next;
                    end
                end else begin
                    header_index_next = header_index_reg + lpd_pkg::HDR_IDX_W'(1);
                end
            end else begin
                bytes_remaining_next = remaining_dec;
                if (remaining_dec == '0) begin
                    in_payload_next   = 1'b0;
                    header_index_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg      <= 1'b0;
            header_index_reg    <= '0;
            length_accum_reg    <= '0;
            bytes_remaining_reg <= '0;
        end else begin
            in_payload_reg      <= in_payload_next;
            header_index_reg    <= header_index_next;
            length_accum_reg    <= length_accum_next;
            bytes_remaining_reg <= bytes_remaining_next;
        end
    end

endmodule

// ----- hw/rtl/lpd_out_reg.sv -----
// ----------------------------------------------------------------------------
// lpd_out_reg: result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module lpd_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  lpd_pkg::result_t result,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             slot_free,
    output lpd_pkg::result_t held
);

    logic             valid_reg, valid_next;
    lpd_pkg::result_t data_reg, data_next;

    // The slot can take a new word when empty or when its word leaves now.
    assign slot_free = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = result.valid;
            data_next  = result;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

endmodule

// ----- hw/rtl/length_prefixed_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer: strips length headers from a byte stream
// Each packet is a header of HEADER_BYTES bytes, whose first four bytes give
// the payload length little-endian, followed by that many payload bytes.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata (low bit up)                 | tuser / tlast
//  --------+-----------+------------------------------------+-----------------------
//  s_      | in        | data_byte[7:0]                     | none
//  m_      | out       | payload_byte[7:0], packet_length   | first_of_packet / last
//
// One byte is taken every cycle while s_tready is high; a payload byte
// appears on the master side in the next cycle, held in a single result register.
// Header bytes and zero-length headers produce no output word.
// The input side stalls only while the result register is full and the
// downstream side does not take it (s_tready follows m_tready then).
// Reset (aresetn low at a clock edge) returns to the start of a header and
// empties the result register.
//
module length_prefixed_packet_deframer #(
    parameter int unsigned HEADER_BYTES = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // payload_byte[7:0], packet_length[39:8]
    output logic        m_tuser,   // first_of_packet
    output logic        m_tlast    // last_of_packet
);

    logic             accept;
    logic             slot_free;
    lpd_pkg::result_t result;
    lpd_pkg::result_t held;

    // A byte is accepted whenever the result slot can take what it yields.
    assign s_tready = slot_free;
    assign accept   = s_tvalid && slot_free;

    lpd_parser #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .data_byte(s_tdata),
        .result   (result)
    );

    // The result register reloads on every accepted byte; a header byte
    // simply loads an empty slot.
    lpd_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .result   (result),
        .out_ready(m_tready),
        .out_valid(m_tvalid),
        .slot_free(slot_free),
        .held     (held)
    );

    assign m_tdata = {held.packet_length, held.payload_byte};
    assign m_tuser = held.first_of_packet;
    assign m_tlast = held.last_of_packet;

endmodule

// ----- hw/rtl/lpd_checker.sv -----
// ----------------------------------------------------------------------------
// lpd_checker: port-level checks of the deframer
// Watches the stream ports and flags output words that break the framing.
// ----------------------------------------------------------------------------
module lpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled output word keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // With the result register empty the input is never stalled.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register empty");

    // A first payload byte belongs to a packet of nonzero length.
    a_first_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[39:8] != 32'd0)
        else $error("first payload byte with zero length");

    // A one-byte packet ends on its first byte.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && m_tdata[39:8] == 32'd1 |-> m_tlast)
        else $error("one-byte packet without last flag");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind length_prefixed_packet_deframer lpd_checker u_lpd_checker (.*);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for length_prefixed_packet_deframer
// Feeds framed byte streams through the slave side and predicts every payload
// word. Each word taken on the master side is compared with the oldest
// prediction. Both sides idle at random, with one stretch of full rate.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HEADER_BYTES = 20;
    // Cycle window in which neither side idles, so the block runs flat out.
    localparam int unsigned FULL_RATE_FROM = 400;
    localparam int unsigned FULL_RATE_TO   = 700;
    localparam int unsigned IDLE_PERCENT   = 26;
    localparam int unsigned RANDOM_WORDS   = 780;
    localparam int unsigned REPORT_LIMIT   = 10;

    // How the header filler bytes and the payload bytes are chosen.
    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } fill_mode_t;

    // One payload word as it should leave the master side.
    typedef struct packed {
        lpd_pkg::byte_t data;
        logic           first;
        logic           last;
        lpd_pkg::len_t  length;
    } payload_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // data_byte[7:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // payload_byte[7:0], packet_length[39:8]
    logic        m_tuser;         // first_of_packet
    logic        m_tlast;         // last_of_packet

    // Stream bytes waiting to be offered, and the payload words still owed.
    lpd_pkg::byte_t stream_q[$];
    payload_word_t  payload_words_q[$];

    // Our own copy of the deframer state, advanced once per accepted byte.
    logic              in_packet = 1'b0;
    lpd_pkg::hdr_idx_t hdr_pos = '0;
    lpd_pkg::len_t     len_acc = '0;
    lpd_pkg::len_t     remaining = '0;

    logic        s_taken = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned words_total = 0;
    int unsigned words_accepted = 0;
    int unsigned mismatches = 0;
    logic        full_rate;

    length_prefixed_packet_deframer #(
        .HEADER_BYTES(HEADER_BYTES)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    assign full_rate = (cycle_count >= FULL_RATE_FROM) && (cycle_count < FULL_RATE_TO);

    // Advance the predicted state by one stream byte. Header bytes only build
    // up the length; a payload byte yields one expected word.
    task automatic deframe_byte(input lpd_pkg::byte_t b);
        payload_word_t w;
        if (!in_packet) begin
            if (hdr_pos == 0)
                len_acc = lpd_pkg::len_t'(b);
            else if (hdr_pos < lpd_pkg::LEN_BYTES)
                len_acc = len_acc | (lpd_pkg::len_t'(b) << (8 * hdr_pos));
            // The last header byte closes the header. A zero length leaves
            // us waiting for the next header straight away.
            if (hdr_pos >= HEADER_BYTES - 1) begin
                hdr_pos = '0;
                if (len_acc != 0) begin
                    in_packet = 1'b1;
                    remaining = len_acc;
                end
            end else begin
                hdr_pos = hdr_pos + 1'b1;
            end
        end else begin
            w.data   = b;
            w.first  = (remaining == len_acc);
            w.last   = (remaining == 1);
            w.length = len_acc;
            payload_words_q.push_back(w);
            remaining = remaining - 1;
            if (remaining == 0) begin
                in_packet = 1'b0;
                hdr_pos   = '0;
            end
        end
    endtask

    function automatic lpd_pkg::byte_t fill_byte(input fill_mode_t mode);
        case (mode)
            FILL_ONES:  return 8'hFF;
            FILL_ZEROS: return 8'h00;
            default:    return lpd_pkg::byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue one packet: a header carrying len, then send_bytes payload bytes.
    // Sending fewer bytes than len leaves the packet open at the end.
    task automatic push_packet(input lpd_pkg::len_t len, input int unsigned send_bytes,
                               input fill_mode_t mode);
        for (int unsigned i = 0; i < HEADER_BYTES; i++) begin
            if (i < lpd_pkg::LEN_BYTES)
                stream_q.push_back(len[8*i +: 8]);
            else
                stream_q.push_back(fill_byte(mode));
        end
        for (int unsigned i = 0; i < send_bytes; i++)
            stream_q.push_back(fill_byte(mode));
    endtask

    // Driver: a new word goes out at the falling edge only once the previous
    // one was taken, so tvalid never drops while a word is pending.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (stream_q.size() != 0 &&
                (full_rate || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= stream_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // The downstream side stalls at random outside the full-rate window.
    always @(negedge aclk) begin
        m_tready <= full_rate || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Monitor: both channels are sampled at the rising edge. The output word
    // is checked before this edge's input is predicted, since a byte taken
    // now cannot show up on the master side until a later edge.
    always @(posedge aclk) begin
        payload_word_t exp_word;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (payload_words_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected word: data %02h first %0b last %0b len %08h",
                                 m_tdata[7:0], m_tuser, m_tlast, m_tdata[39:8]);
                end else begin
                    exp_word = payload_words_q.pop_front();
                    if (m_tdata[7:0] !== exp_word.data || m_tuser !== exp_word.first ||
                        m_tlast !== exp_word.last || m_tdata[39:8] !== exp_word.length) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"mismatch: expected data %02h first %0b last %0b ",
                                      "len %08h, got data %02h first %0b last %0b len %08h"},
                                     exp_word.data, exp_word.first, exp_word.last,
                                     exp_word.length, m_tdata[7:0], m_tuser, m_tlast,
                                     m_tdata[39:8]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                words_accepted++;
            end
        end
    end

    initial begin
        int unsigned   pick;
        lpd_pkg::len_t len;

        // Directed part. A one-byte packet carries both flags on one word,
        // and two zero-length headers in a row must produce nothing at all.
        push_packet(32'd1, 1, FILL_ONES);
        push_packet(32'd0, 0, FILL_ZEROS);
        push_packet(32'd0, 0, FILL_ONES);
        push_packet(32'd2, 2, FILL_ZEROS);

        // Random packets, mostly short, some zero-length, a few longer, up to 300
        // bytes, so that some use the second length byte.
        while (stream_q.size() < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                len = 32'd0;
            else if (pick < 85)
                len = lpd_pkg::len_t'($urandom_range(1, 12));
            else
                len = lpd_pkg::len_t'($urandom_range(13, 300));
            push_packet(len, len, FILL_RANDOM);
        end

        // An oversized length is simply counted through; the run ends while
        // that packet is still open, with every length bit set.
        push_packet(32'hFFFF_FFFF, 40, FILL_RANDOM);
        words_total = stream_q.size();

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (words_accepted < words_total) @(posedge aclk);
        while (payload_words_q.size() != 0) @(posedge aclk);
        // Wait on to catch any stray word behind the last one.
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

endmodule
